@@ rtl/md5bc_pkg.sv @@
// md5bc_pkg: shared types, constants and round tables of the md5 compression block
`timescale 1ns / 1ps
package md5bc_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned BLOCK_WORDS = 16;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        new_message;
    logic        emit_digest;
  } md5bc_msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } md5bc_dig_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5bc_abcd_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_ROUND,
    ST_FINAL
  } md5bc_state_t;

  // round constant per round
  function automatic logic [31:0] md5bc_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount, picked by phase and round within a group of four
  function automatic logic [4:0] md5bc_shift(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word index used by a round
  function automatic logic [3:0] md5bc_widx(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] g;
    lo = r[3:0];
    case (r[5:4])
      2'd0: g = lo;
      2'd1: g = (lo << 2) + lo + 4'd1;
      2'd2: g = (lo << 1) + lo + 4'd5;
      2'd3: g = (lo << 3) - lo;
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5bc_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

@@ rtl/md5bc_msg_mem.sv @@
// md5bc_msg_mem: 16-word block buffer, one write port and one registered read port
`timescale 1ns / 1ps
module md5bc_msg_mem import md5bc_pkg::*; (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [BLOCK_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/md5bc_round.sv @@
// md5bc_round: one md5 round step on the working registers
`timescale 1ns / 1ps
module md5bc_round import md5bc_pkg::*; (
  input  md5bc_abcd_t cur,
  input  logic [5:0]  rnd,
  input  logic [31:0] m,
  output md5bc_abcd_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;

  always_comb begin
    case (rnd[5:4])
      2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1: f = (cur.d & cur.b) | (~cur.d & cur.c);
      2'd2: f = cur.b ^ cur.c ^ cur.d;
      2'd3: f = cur.c ^ (cur.b | ~cur.d);
      default: f = '0;
    endcase
    sum = f + cur.a + md5bc_k(rnd) + m;
    nxt.a = cur.d;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.b + md5bc_rotl(sum, md5bc_shift(rnd));
  end

endmodule

@@ rtl/md5_block_compress.sv @@
// md5_block_compress: md5 compression over a stream of 32-bit message words
//
// Input channel msg (msg_valid/msg_ready) carries one 32-bit word per
// handshake, sixteen words per padded 512-bit block, little-endian bytes.
// new_message on a word reloads the standard initial chaining values before
// that word is taken; emit_digest on the sixteenth word requests the digest.
// Output channel dig (dig_valid/dig_ready) carries the chaining words A, B,
// C, D in that order, digest_last set on D.
// Words are written into a 16-entry buffer memory at one per cycle while
// msg_ready is high. After the sixteenth word msg_ready drops while the
// block is compressed: a prime state issues the first buffer read, 64
// rounds follow with one buffer read per round, and a final state does the
// chaining addition. The digest is copied into a four-word output buffer
// and the first word is offered the cycle after the addition.
// A stalled receiver holds the output buffer; input keeps flowing and only a
// following digest-requesting block waits before its addition until the
// earlier digest is fully taken. Synchronous reset loads the initial values,
// clears the word count and empties the output buffer.
`timescale 1ns / 1ps
module md5_block_compress import md5bc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  md5bc_msg_t msg,
  output logic       dig_valid,
  input  logic       dig_ready,
  output md5bc_dig_t dig
);

  md5bc_state_t state;
  md5bc_state_t state_next;
  logic [3:0]   word_count;
  logic [5:0]   rnd;
  logic [5:0]   rnd_inc;
  logic         emit_pending;
  md5bc_abcd_t  chain;
  md5bc_abcd_t  work;
  md5bc_abcd_t  work_next;
  md5bc_abcd_t  chain_sum;
  logic [31:0]  out_buf [4];
  logic [1:0]   out_idx;
  logic         out_busy;
  logic         msg_take;
  logic         finish;
  logic [3:0]   raddr;
  logic [31:0]  rdata;

  md5bc_msg_mem u_mem (
    .clk   (clk),
    .we    (msg_take),
    .waddr (word_count),
    .wdata (msg.msg_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  md5bc_round u_round (
    .cur (work),
    .rnd (rnd),
    .m   (rdata),
    .nxt (work_next)
  );

  assign rnd_inc = rnd + 6'd1;
  assign chain_sum.a = chain.a + work.a;
  assign chain_sum.b = chain.b + work.b;
  assign chain_sum.c = chain.c + work.c;
  assign chain_sum.d = chain.d + work.d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    msg_ready  = 1'b0;
    finish     = 1'b0;
    raddr      = '0;
    case (state)
      ST_LOAD: begin
        msg_ready = 1'b1;
        if (msg_valid && word_count == 4'd15) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        // read for round 0 goes out now
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        raddr = md5bc_widx(rnd_inc);
        if (rnd == 6'(NUM_ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        // hold while an earlier digest still sits in the output buffer
        if (!(emit_pending && out_busy)) begin
          finish     = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
    if (state == ST_PREP) begin
      raddr = md5bc_widx('0);
    end
  end

  assign msg_take = msg_valid && msg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= '0;
      rnd          <= '0;
      emit_pending <= 1'b0;
      chain        <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
      work         <= '0;
      out_busy     <= 1'b0;
      out_idx      <= '0;
    end else begin
      if (msg_take) begin
        word_count <= word_count + 4'd1;
        if (msg.new_message) begin
          chain <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
        end
        if (word_count == 4'd15) begin
          emit_pending <= msg.emit_digest;
        end
      end
      if (state == ST_PREP) begin
        work <= chain;
        rnd  <= '0;
      end
      if (state == ST_ROUND) begin
        work <= work_next;
        rnd  <= rnd_inc;
      end
      if (dig_valid && dig_ready) begin
        out_idx <= out_idx + 2'd1;
        if (out_idx == 2'd3) begin
          out_busy <= 1'b0;
        end
      end
      if (finish) begin
        chain <= chain_sum;
        if (emit_pending) begin
          out_busy <= 1'b1;
          out_idx  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish && emit_pending) begin
      out_buf[0] <= chain_sum.a;
      out_buf[1] <= chain_sum.b;
      out_buf[2] <= chain_sum.c;
      out_buf[3] <= chain_sum.d;
    end
  end

  assign dig_valid       = out_busy;
  assign dig.digest_word = out_buf[out_idx];
  assign dig.digest_last = (out_idx == 2'd3);

  a_full_block_starts: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && msg_ready && word_count == 4'd15) |=> (state == ST_PREP))
    else $error("sixteenth word did not start compression");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'(NUM_ROUNDS - 1)) |=> (state == ST_FINAL))
    else $error("round sequence did not end after last round");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP || state == ST_ROUND || state == ST_FINAL) |-> !msg_ready)
    else $error("input accepted during compression");

  a_digest_drains: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && dig.digest_last) |=> !dig_valid)
    else $error("new digest loaded before previous one drained");

  a_count_zero_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (word_count == 4'd0))
    else $error("word count not cleared at block end");

endmodule

@@ tb/tb_md5_block_compress.sv @@
// tb_md5_block_compress: self-checking testbench for the md5 block compression unit
`timescale 1ns / 1ps
module tb_md5_block_compress;
  import md5bc_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTS = 20;

  // per-round additive constants, round 0 in the top word
  localparam logic [64*32-1:0] RCONST = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, four per phase, first entry in the top bits
  localparam logic [16*5-1:0] ROT_AMT = {
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       msg_valid = 1'b0;
  logic       msg_ready;
  md5bc_msg_t msg = '0;
  logic       dig_valid;
  logic       dig_ready = 1'b0;
  md5bc_dig_t dig;

  // predictor state
  md5bc_abcd_t chain;
  logic [31:0] blk_words [16];
  int          blk_fill;
  md5bc_dig_t  digest_q [$];
  md5bc_dig_t  digest_head;

  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;
  logic hold_trig = 1'b0;
  logic hold_seen;
  int   hold_left;
  int   stall_left;

  int err_count = 0;
  int words_sent = 0;
  int digests_checked = 0;

  md5_block_compress uut (
    .clk(clk),
    .rst(rst),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .msg(msg),
    .dig_valid(dig_valid),
    .dig_ready(dig_ready),
    .dig(dig)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic md5_reset_chain();
    chain = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
  endtask

  // absorb one accepted word; compress after the sixteenth and queue the digest if requested
  task automatic md5_absorb(input logic [31:0] w, input logic nm, input logic em);
    logic [31:0] a, b, c, d, f;
    int r, phase, g, s;
    if (nm) md5_reset_chain();
    blk_words[blk_fill] = w;
    if (blk_fill != 15) begin
      blk_fill++;
    end else begin
      blk_fill = 0;
      a = chain.a;
      b = chain.b;
      c = chain.c;
      d = chain.d;
      for (r = 0; r < 64; r++) begin
        phase = r / 16;
        case (phase)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = 5 * r + 1;
          end
          2: begin
            f = b ^ c ^ d;
            g = 3 * r + 5;
          end
          default: begin
            f = c ^ (b | ~d);
            g = 7 * r;
          end
        endcase
        f = f + a + RCONST[(63 - r) * 32 +: 32] + blk_words[g % 16];
        s = ROT_AMT[(15 - (phase * 4 + r % 4)) * 5 +: 5];
        a = d;
        d = c;
        c = b;
        b = b + ((f << s) | (f >> (32 - s)));
      end
      chain.a = chain.a + a;
      chain.b = chain.b + b;
      chain.c = chain.c + c;
      chain.d = chain.d + d;
      if (em) begin
        digest_q.push_back('{digest_word: chain.a, digest_last: 1'b0});
        digest_q.push_back('{digest_word: chain.b, digest_last: 1'b0});
        digest_q.push_back('{digest_word: chain.c, digest_last: 1'b0});
        digest_q.push_back('{digest_word: chain.d, digest_last: 1'b1});
      end
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input logic [31:0] w, input logic nm, input logic em);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= {w, nm, em};
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    md5_absorb(w, nm, em);
    words_sent++;
  endtask

  // one block of random content; flags on other words are noise
  task automatic send_rand_block(input logic nm_first, input logic em_last,
                                 input int noise_div);
    int i;
    logic nm, em;
    for (i = 0; i < 16; i++) begin
      nm = (i == 0) ? nm_first : (noise_div > 0 && $urandom_range(1, noise_div) == 1);
      em = (i == 15) ? em_last : (noise_div > 0 && $urandom_range(1, noise_div) == 1);
      send_word(rand_word(), nm, em);
    end
  endtask

  // sender goes quiet until every queued digest word has been seen
  task automatic wait_digests_drained();
    msg_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // padded empty message: a single 0x80 byte then zeros
  task automatic test_empty_message();
    int i;
    for (i = 0; i < 16; i++)
      send_word((i == 0) ? 32'h00000080 : 32'h0, i == 0, i == 15);
  endtask

  // extreme words, restart mid-block, emit flag on a non-final word
  task automatic test_extremes();
    int i;
    for (i = 0; i < 16; i++)
      send_word((i % 2 == 0) ? 32'hffffffff : 32'h0, i == 7, i == 3 || i == 15);
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    int i;
    hold_trig <= ~hold_trig;
    for (i = 0; i < 3; i++) send_rand_block(i == 0, 1'b1, 0);
  endtask

  // two chained blocks, only the second emitting, then a full stop until all digests arrive
  task automatic test_pause_and_chain();
    send_rand_block(1'b1, 1'b0, 0);
    send_rand_block(1'b0, 1'b1, 0);
    wait_digests_drained();
  endtask

  task automatic test_random_stream();
    int i;
    for (i = 0; i < 12; i++)
      send_rand_block(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                      (i % 3 == 2) ? 6 : 0);
  endtask

  task automatic test_full_rate();
    int i;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (i = 0; i < 3; i++) send_rand_block(i != 1, i != 2, 0);
  endtask

  // digest receiver: random stall bursts plus a long hold when triggered
  always @(posedge clk) begin
    if (rst) begin
      dig_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES - 1;
      dig_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      dig_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      dig_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      dig_ready <= 1'b0;
    end else begin
      dig_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && dig_valid && dig_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", dig.digest_word, 32'h0);
      end else begin
        digest_head = digest_q.pop_front();
        if (dig.digest_word !== digest_head.digest_word)
          report_mismatch("digest_word", dig.digest_word, digest_head.digest_word);
        if (dig.digest_last !== digest_head.digest_last)
          report_mismatch("digest_last", 32'(dig.digest_last),
                          32'(digest_head.digest_last));
      end
      digests_checked++;
    end
  end

  initial begin
    #2000000;
    $display("md5_block_compress verification failed");
    $finish;
  end

  initial begin : main_seq
    int n;
    md5_reset_chain();
    blk_fill = 0;
    for (n = 0; n < 16; n++) blk_words[n] = 32'h0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_message();
    test_extremes();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_backpressure();
    test_pause_and_chain();
    test_random_stream();
    test_full_rate();
    msg_valid <= 1'b0;

    n = 0;
    while (digest_q.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (digest_q.size() != 0) begin
      digest_head = digest_q.pop_front();
      report_mismatch("missing digest word", 32'h0, digest_head.digest_word);
    end

    $display("sent %0d message words (%0d blocks), checked %0d digest words",
             words_sent, words_sent / 16, digests_checked);
    $display("included restarts mid-block, stray emit flags, long output stall");
    if (err_count == 0) begin
      $display("md5_block_compress verification clean");
    end else begin
      $display("md5_block_compress verification failed");
    end
    $finish;
  end

endmodule
